/* sv/rsfr_pkg.sv */
package rsfr_pkg;

	// parser states
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_ADDR    = 4'd1,
		ST_SOURCE  = 4'd2,
		ST_COMMAND = 4'd3,
		ST_LENHI   = 4'd4,
		ST_LENLO   = 4'd5,
		ST_PAYLOAD = 4'd6,
		ST_CHECK   = 4'd7,
		ST_POLL    = 4'd8,
		ST_ESCAPE  = 4'd9
	} parse_state_t;

	// result events
	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_DATA = 3'd1,
		EV_GOOD = 3'd2,
		EV_BAD  = 3'd3,
		EV_POLL = 3'd4,
		EV_NAK  = 3'd5,
		EV_ACK  = 3'd6
	} event_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_START_PACKET = 3'd0,
		CFG_START_POLL   = 3'd1,
		CFG_ESCAPE       = 3'd2,
		CFG_ACK          = 3'd3,
		CFG_NAK          = 3'd4,
		CFG_OWN_ADDRESS  = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;

	localparam logic [7:0] START_PACKET_RST = 8'h7F;
	localparam logic [7:0] START_POLL_RST   = 8'h8F;
	localparam logic [7:0] ESCAPE_RST       = 8'h8E;
	localparam logic [7:0] ACK_RST          = 8'h06;
	localparam logic [7:0] NAK_RST          = 8'h15;
	localparam logic [7:0] OWN_ADDRESS_RST  = 8'h01;

	// escaped byte substitutions
	localparam logic [7:0] ESC_SEQ_ONE = 8'h01;
	localparam logic [7:0] ESC_VAL_ONE = 8'h7F;
	localparam logic [7:0] ESC_SEQ_TWO = 8'h02;
	localparam logic [7:0] ESC_VAL_TWO = 8'h8F;

	localparam logic [15:0] MAX_PAYLOAD = 16'd128;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic is_start_packet;
		logic is_start_poll;
		logic is_escape;
		logic is_ack;
		logic is_nak;
		logic is_own_raw;
		logic is_own_unesc;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  raw_byte;
		logic [7:0]  unesc_byte;
		byte_class_t cls;
	} rsfr_item_t;

endpackage

/* sv/rsfr_front.sv */
module rsfr_front import rsfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   push,
	input  logic [7:0]             rx_byte,
	input  logic                   queue_full,
	output logic                   wr_en,
	output rsfr_item_t             wr_item
);

	logic [7:0] start_packet_q;
	logic [7:0] start_poll_q;
	logic [7:0] escape_q;
	logic [7:0] ack_q;
	logic [7:0] nak_q;
	logic [7:0] own_address_q;
	logic [7:0] unesc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_packet_q <= START_PACKET_RST;
			start_poll_q   <= START_POLL_RST;
			escape_q       <= ESCAPE_RST;
			ack_q          <= ACK_RST;
			nak_q          <= NAK_RST;
			own_address_q  <= OWN_ADDRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_PACKET: start_packet_q <= cfg_data;
				CFG_START_POLL:   start_poll_q   <= cfg_data;
				CFG_ESCAPE:       escape_q       <= cfg_data;
				CFG_ACK:          ack_q          <= cfg_data;
				CFG_NAK:          nak_q          <= cfg_data;
				CFG_OWN_ADDRESS:  own_address_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte as it reads after an escape code
	always_comb begin
		case (rx_byte)
			ESC_SEQ_ONE: unesc = ESC_VAL_ONE;
			ESC_SEQ_TWO: unesc = ESC_VAL_TWO;
			default:     unesc = rx_byte;
		endcase
	end

	assign wr_en                        = push && !queue_full;
	assign wr_item.raw_byte             = rx_byte;
	assign wr_item.unesc_byte           = unesc;
	assign wr_item.cls.is_start_packet  = (rx_byte == start_packet_q);
	assign wr_item.cls.is_start_poll    = (rx_byte == start_poll_q);
	assign wr_item.cls.is_escape        = (rx_byte == escape_q);
	assign wr_item.cls.is_ack           = (rx_byte == ack_q);
	assign wr_item.cls.is_nak           = (rx_byte == nak_q);
	assign wr_item.cls.is_own_raw       = (rx_byte == own_address_q);
	assign wr_item.cls.is_own_unesc     = (unesc == own_address_q);

endmodule

/* sv/rsfr_fifo.sv */
module rsfr_fifo import rsfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  rsfr_item_t wr_item,
	input  logic       rd_en,
	output rsfr_item_t rd_item,
	output logic       not_empty,
	output logic       full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rsfr_item_t      slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_item   = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

endmodule

/* sv/rsfr_back.sv */
module rsfr_back import rsfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  rsfr_item_t  item,
	output logic        item_take,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [7:0]  command_code,
	output logic [15:0] payload_length
);

	parse_state_t state_q, state_d;
	parse_state_t resume_q, resume_d;
	parse_state_t td_state;
	logic [7:0]   sum_q, sum_d;
	logic [15:0]  left_q, left_d;
	logic [15:0]  length_q, length_d;
	logic [7:0]   command_q, command_d;
	logic         out_valid_q;
	event_t       event_q, ev_d;
	logic [7:0]   data_q, data_d;
	logic         td;
	logic [7:0]   td_byte;
	logic         td_esc;
	logic         td_own;
	logic [15:0]  len_full;
	logic [15:0]  left_dec;
	logic [7:0]   sum_chk;

	assign item_take = item_valid && (!out_valid_q || pop);

	always_comb begin
		ev_d      = EV_NONE;
		data_d    = '0;
		state_d   = state_q;
		resume_d  = resume_q;
		sum_d     = sum_q;
		left_d    = left_q;
		length_d  = length_q;
		command_d = command_q;
		td        = 1'b0;
		td_state  = state_q;
		td_byte   = item.raw_byte;
		td_esc    = 1'b0;
		td_own    = item.cls.is_own_raw;
		len_full  = {length_q[15:8], td_byte};
		left_dec  = (left_q != '0) ? left_q - 16'd1 : left_q;
		sum_chk   = sum_q + td_byte;

		case (state_q)
			ST_ESCAPE: begin
				td       = 1'b1;
				td_state = resume_q;
				td_byte  = item.unesc_byte;
				td_esc   = 1'b1;
				td_own   = item.cls.is_own_unesc;
			end
			ST_IDLE: begin
				if (item.cls.is_start_packet) begin
					sum_d   = item.raw_byte;
					state_d = ST_ADDR;
				end else if (item.cls.is_start_poll) begin
					state_d = ST_POLL;
				end else if (item.cls.is_ack) begin
					ev_d = EV_ACK;
				end else if (item.cls.is_nak) begin
					ev_d = EV_NAK;
				end
			end
			ST_CHECK: begin
				if (item.cls.is_escape) begin
					resume_d = ST_CHECK;
					state_d  = ST_ESCAPE;
				end else begin
					td = 1'b1;
				end
			end
			ST_ADDR, ST_SOURCE, ST_COMMAND, ST_LENHI, ST_LENLO, ST_PAYLOAD, ST_POLL: begin
				if (item.cls.is_start_packet) begin
					sum_d   = item.raw_byte;
					state_d = ST_ADDR;
				end else if (item.cls.is_start_poll) begin
					state_d = ST_POLL;
				end else if (item.cls.is_escape &&
					!((state_q == ST_ADDR || state_q == ST_POLL) && item.cls.is_own_raw)) begin
					resume_d = state_q;
					state_d  = ST_ESCAPE;
				end else begin
					td = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// recompute byte-dependent terms once the escaped byte is chosen
		len_full = {length_q[15:8], td_byte};
		sum_chk  = sum_q + td_byte;

		if (td) begin
			case (td_state)
				ST_ADDR: begin
					if (td_own) begin
						sum_d   = sum_q + td_byte;
						state_d = ST_SOURCE;
					end else begin
						state_d = ST_IDLE;
						if (td_esc) begin
							ev_d = EV_BAD;
						end
					end
				end
				ST_SOURCE: begin
					sum_d   = sum_q + td_byte;
					state_d = ST_COMMAND;
				end
				ST_COMMAND: begin
					command_d = td_byte;
					sum_d     = sum_q + td_byte;
					state_d   = ST_LENHI;
				end
				ST_LENHI: begin
					length_d = {td_byte, 8'h00};
					sum_d    = sum_q + td_byte;
					state_d  = ST_LENLO;
				end
				ST_LENLO: begin
					length_d = len_full;
					left_d   = len_full;
					sum_d    = sum_q + td_byte;
					if (len_full > MAX_PAYLOAD) begin
						ev_d    = EV_BAD;
						state_d = ST_IDLE;
					end else if (len_full == '0) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					ev_d    = EV_DATA;
					data_d  = td_byte;
					sum_d   = sum_q + td_byte;
					left_d  = left_dec;
					state_d = (left_dec == '0) ? ST_CHECK : ST_PAYLOAD;
				end
				ST_CHECK: begin
					ev_d    = (sum_chk == '0) ? EV_GOOD : EV_BAD;
					state_d = ST_IDLE;
				end
				ST_POLL: begin
					if (td_own) begin
						ev_d = EV_POLL;
					end
					state_d = ST_IDLE;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			resume_q    <= ST_IDLE;
			sum_q       <= '0;
			left_q      <= '0;
			length_q    <= '0;
			command_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				state_q     <= state_d;
				resume_q    <= resume_d;
				sum_q       <= sum_d;
				left_q      <= left_d;
				length_q    <= length_d;
				command_q   <= command_d;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			event_q <= ev_d;
			data_q  <= data_d;
		end
	end

	assign empty          = !out_valid_q;
	assign event_res      = event_q;
	assign data_byte      = data_q;
	assign command_code   = command_q;
	assign payload_length = length_q;

endmodule

/* sv/rs485_frame_receiver.sv */
// byte-stuffed bus frame receiver. every byte pushed in gives exactly one result beat:
// an event code, the unescaped payload byte (zero unless the event is a payload byte),
// and the command and declared length of the frame in progress. one byte is taken per
// clock while the queue is not full; a byte lands in a short queue at the edge it is
// accepted. the front end compares each byte against the configured codes, the queue
// decouples it from the parser, and the parser's single state update per byte is what
// sets the rate of one byte per cycle unless a result waits unpopped. full rises only
// when the queue has filled because results are not being popped. configuration
// registers are written through the cfg channel, which is always ready; write them only
// while no bytes are in flight. indexes outside the register list are ignored
module rs485_frame_receiver import rsfr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// byte input, queue style
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             rx_byte,
	// result output, queue style
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             event_res,
	output logic [7:0]             data_byte,
	output logic [7:0]             command_code,
	output logic [15:0]            payload_length,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	logic       wr_en;
	rsfr_item_t wr_item;
	rsfr_item_t rd_item;
	logic       rd_en;
	logic       q_not_empty;

	// configuration is a plain register file, never back-pressured
	assign cfg_ready = 1'b1;

	// front: code compares and unescaping of each accepted beat
	rsfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.rx_byte    (rx_byte),
		.queue_full (full),
		.wr_en      (wr_en),
		.wr_item    (wr_item)
	);

	// classified bytes waiting for the parser
	rsfr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_item   (wr_item),
		.rd_en     (rd_en),
		.rd_item   (rd_item),
		.not_empty (q_not_empty),
		.full      (full)
	);

	// back: frame parser with its result register
	rsfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (q_not_empty),
		.item           (rd_item),
		.item_take      (rd_en),
		.pop            (pop),
		.empty          (empty),
		.event_res      (event_res),
		.data_byte      (data_byte),
		.command_code   (command_code),
		.payload_length (payload_length)
	);

endmodule

/* sv/rsfr_checker.sv */
module rsfr_checker import rsfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  event_res,
	input logic [7:0]  data_byte,
	input logic [15:0] payload_length
);

	// nothing to pop at the edge after one that saw reset held
	assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown during reset");

	// a waiting beat holds until it is popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_res) && $stable(data_byte)))
		else $error("waiting result changed");

	// only payload beats carry a data byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_res != EV_DATA) |-> data_byte == 8'h00)
		else $error("data byte on a non-payload event");

	// payload only streams for an accepted, non-zero length
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_res == EV_DATA) |->
		(payload_length != 16'd0 && payload_length <= MAX_PAYLOAD))
		else $error("payload beat with an out-of-range length");

	// no event code beyond the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> event_res != 3'd7)
		else $error("undefined event code");

endmodule

bind rs485_frame_receiver rsfr_checker u_rsfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.event_res      (event_res),
	.data_byte      (data_byte),
	.payload_length (payload_length)
);

/* verif/rs485_frame_receiver_tb.sv */
module rs485_frame_receiver_tb;
	import rsfr_pkg::*;

	// consecutive cycles with no beat moving on any channel before giving up
	localparam int STALL_LIMIT = 2000;
	// cycles watched for stray beats once every expected result has arrived
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// one result beat as the parser should produce it
	typedef struct packed {
		event_t      ev;
		logic [7:0]  data;
		logic [7:0]  cmd;
		logic [15:0] len;
	} rx_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic [7:0]             rx_byte = 8'h00;
	logic                   pop = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data = 8'h00;
	logic                   full;
	logic                   empty;
	logic [2:0]             event_res;
	logic [7:0]             data_byte;
	logic [7:0]             command_code;
	logic [15:0]            payload_length;
	logic                   cfg_ready;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rs485_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.event_res     (event_res),
		.data_byte     (data_byte),
		.command_code  (command_code),
		.payload_length(payload_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// our own copy of the code registers, tracking every write the block takes
	logic [7:0] code_start = START_PACKET_RST;
	logic [7:0] code_poll = START_POLL_RST;
	logic [7:0] code_escape = ESCAPE_RST;
	logic [7:0] code_ack = ACK_RST;
	logic [7:0] code_nak = NAK_RST;
	logic [7:0] my_address = OWN_ADDRESS_RST;

	// parser state as it should stand after every accepted byte
	parse_state_t rx_state = ST_IDLE;
	parse_state_t rx_resume = ST_IDLE;
	logic [7:0]   rx_sum = 8'h00;
	logic [15:0]  rx_left = 16'h0000;
	logic [15:0]  rx_len = 16'h0000;
	logic [7:0]   rx_cmd = 8'h00;
	event_t       rx_event;
	logic [7:0]   rx_data;

	rx_result_t pending_results[$];
	// bytes of the next sequence to put on the line, already stuffed
	logic [7:0] line_bytes[$];
	logic [7:0] frame_sum;

	int  send_gap_pct = 0;
	int  recv_stall_pct = 0;
	bit  push_held = 1'b0;
	int  bytes_sent = 0;
	int  beats_checked = 0;
	int  mismatch_count = 0;
	int  register_sets = 0;
	int  quiet_cycles = 0;
	int  tally [8] = '{default: 0};

	// one field byte in the state it lands in, unescaped already where it was escaped
	function automatic void take_field(parse_state_t st, logic [7:0] b, bit escaped);
		case (st)
			ST_ADDR: begin
				if (b == my_address) begin
					rx_sum += b;
					rx_state = ST_SOURCE;
				end else begin
					// a foreign address is only an error when it came escaped
					rx_state = ST_IDLE;
					if (escaped)
						rx_event = EV_BAD;
				end
			end
			ST_SOURCE: begin
				rx_sum += b;
				rx_state = ST_COMMAND;
			end
			ST_COMMAND: begin
				rx_cmd = b;
				rx_sum += b;
				rx_state = ST_LENHI;
			end
			ST_LENHI: begin
				rx_len = {b, 8'h00};
				rx_sum += b;
				rx_state = ST_LENLO;
			end
			ST_LENLO: begin
				rx_len = rx_len | {8'h00, b};
				rx_sum += b;
				rx_left = rx_len;
				if (rx_len > MAX_PAYLOAD) begin
					rx_event = EV_BAD;
					rx_state = ST_IDLE;
				end else if (rx_len == 16'h0000) begin
					rx_state = ST_CHECK;
				end else begin
					rx_state = ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				rx_event = EV_DATA;
				rx_data = b;
				rx_sum += b;
				if (rx_left != 16'h0000)
					rx_left--;
				rx_state = (rx_left == 16'h0000) ? ST_CHECK : ST_PAYLOAD;
			end
			ST_CHECK: begin
				// checksum plus running sum wraps to zero on a good frame
				rx_event = (8'(b + rx_sum) == 8'h00) ? EV_GOOD : EV_BAD;
				rx_state = ST_IDLE;
			end
			ST_POLL: begin
				if (b == my_address)
					rx_event = EV_POLL;
				rx_state = ST_IDLE;
			end
			default: begin
				rx_state = ST_IDLE;
			end
		endcase
	endfunction

	// advances the parser by one line byte and queues the beat it must give
	function automatic void parse_byte(logic [7:0] raw);
		logic [7:0]   b;
		parse_state_t st;
		rx_result_t   r;
		b = raw;
		st = rx_state;
		rx_event = EV_NONE;
		rx_data = 8'h00;
		if (st == ST_ESCAPE) begin
			// whatever follows the escape code is data, never a control code
			if (b == ESC_SEQ_ONE)
				b = ESC_VAL_ONE;
			else if (b == ESC_SEQ_TWO)
				b = ESC_VAL_TWO;
			take_field(rx_resume, b, 1'b1);
		end else if (st == ST_IDLE) begin
			if (b == code_start) begin
				rx_sum = b;
				rx_state = ST_ADDR;
			end else if (b == code_poll) begin
				rx_state = ST_POLL;
			end else if (b == code_ack) begin
				rx_event = EV_ACK;
			end else if (b == code_nak) begin
				rx_event = EV_NAK;
			end
		end else if (st == ST_CHECK) begin
			// start codes do not resynchronise while the checksum is due
			if (b == code_escape) begin
				rx_resume = st;
				rx_state = ST_ESCAPE;
			end else begin
				take_field(st, b, 1'b0);
			end
		end else begin
			if (b == code_start) begin
				rx_sum = b;
				rx_state = ST_ADDR;
			end else if (b == code_poll) begin
				rx_state = ST_POLL;
			end else if ((st == ST_ADDR || st == ST_POLL) && b == my_address) begin
				take_field(st, b, 1'b0);
			end else if (b == code_escape) begin
				rx_resume = st;
				rx_state = ST_ESCAPE;
			end else begin
				take_field(st, b, 1'b0);
			end
		end
		r.ev = rx_event;
		r.data = rx_data;
		r.cmd = rx_cmd;
		r.len = rx_len;
		pending_results.push_back(r);
	endfunction

	// random byte leaning hard on the values the parser treats specially
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return code_start;
			1: return code_poll;
			2: return code_escape;
			3: return code_ack;
			4: return code_nak;
			5: return my_address;
			6: return ESC_SEQ_ONE;
			7: return ESC_SEQ_TWO;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// byte stuffing; a value that cannot be expressed escaped just goes out wrong
	function automatic void stuff(logic [7:0] v, bit in_check, bit force_esc);
		bit need;
		need = force_esc || v == code_escape || (!in_check && (v == code_start || v == code_poll));
		if (need) begin
			line_bytes.push_back(code_escape);
			if (v == ESC_VAL_ONE)
				line_bytes.push_back(ESC_SEQ_ONE);
			else if (v == ESC_VAL_TWO)
				line_bytes.push_back(ESC_SEQ_TWO);
			else
				line_bytes.push_back(v);
		end else begin
			line_bytes.push_back(v);
		end
	endfunction

	function automatic void add_field(logic [7:0] v, bit force_esc);
		frame_sum += v;
		stuff(v, 1'b0, force_esc);
	endfunction

	function automatic void open_frame(logic [7:0] addr, logic [7:0] src, logic [7:0] cmd,
			logic [15:0] len, bit esc_addr);
		line_bytes.delete();
		line_bytes.push_back(code_start);
		frame_sum = code_start;
		add_field(addr, esc_addr);
		add_field(src, 1'b0);
		add_field(cmd, 1'b0);
		add_field(len[15:8], 1'b0);
		add_field(len[7:0], 1'b0);
	endfunction

	function automatic void close_frame(bit corrupt);
		logic [7:0] chk;
		chk = -frame_sum;
		if (corrupt)
			chk ^= 8'($urandom_range(1, 255));
		stuff(chk, 1'b1, 1'b0);
	endfunction

	// one byte beat; push is left high so a following byte can go back to back
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
		push_held = 1'b1;
	endtask

	// sends the prepared line, optionally holding off before one byte until all drained
	task automatic send_line(input int pause_at);
		foreach (line_bytes[i]) begin
			if (i == pause_at)
				wait_drained();
			send_byte(line_bytes[i]);
		end
	endtask

	task automatic wait_drained();
		if (push_held) begin
			push <= 1'b0;
			push_held = 1'b0;
			@(posedge clk);
		end
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// writes all six registers plus the spare indexes, which the block must ignore
	task automatic write_registers(input logic [7:0] sp, input logic [7:0] spoll,
			input logic [7:0] esc, input logic [7:0] ack, input logic [7:0] nak,
			input logic [7:0] own);
		logic [7:0]             vals [6];
		logic [7:0]             data;
		logic [CFG_INDEX_W-1:0] idx;
		vals = '{sp, spoll, esc, ack, nak, own};
		wait_drained();
		for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
			idx = i[CFG_INDEX_W-1:0];
			if (i <= CFG_OWN_ADDRESS)
				data = vals[i];
			else
				data = 8'($urandom_range(0, 255));
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx)
				CFG_START_PACKET: code_start = data;
				CFG_START_POLL:   code_poll = data;
				CFG_ESCAPE:       code_escape = data;
				CFG_ACK:          code_ack = data;
				CFG_NAK:          code_nak = data;
				CFG_OWN_ADDRESS:  my_address = data;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		register_sets++;
	endtask

	// mostly well-formed frames and polls with random content, the rest broken or noise
	task automatic run_traffic(input int n_bytes, input int gap_pct, input int stall_pct);
		int         first_count;
		int         kind;
		int         r;
		int         len;
		int         n;
		int         pause_at;
		logic [7:0] addr;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		first_count = bytes_sent;
		while (bytes_sent - first_count < n_bytes) begin
			kind = $urandom_range(0, 99);
			line_bytes.delete();
			if (kind < 65) begin
				// short payloads mostly, now and then the longest legal one or oversize
				r = $urandom_range(0, 99);
				if (r < 72)
					len = $urandom_range(0, 6);
				else if (r < 90)
					len = $urandom_range(7, 24);
				else if (r < 94)
					len = int'(MAX_PAYLOAD);
				else if (r < 97)
					len = int'(MAX_PAYLOAD) + 1;
				else
					len = $urandom_range(int'(MAX_PAYLOAD) + 2, 16'hFFFF);
				addr = ($urandom_range(0, 9) == 0) ? pick_byte() : my_address;
				open_frame(addr, pick_byte(), pick_byte(), 16'(len),
					$urandom_range(0, 7) == 0);
				if (len <= int'(MAX_PAYLOAD)) begin
					for (int i = 0; i < len; i++)
						add_field(pick_byte(), 1'b0);
					close_frame($urandom_range(0, 9) == 0);
				end
				// frame cut short, the next sequence has to resynchronise
				if (kind >= 55) begin
					n = $urandom_range(1, line_bytes.size() - 1);
					while (line_bytes.size() > n)
						void'(line_bytes.pop_back());
				end
			end else if (kind < 77) begin
				line_bytes.push_back(code_poll);
				if ($urandom_range(0, 3) == 0)
					line_bytes.push_back(code_escape);
				line_bytes.push_back(($urandom_range(0, 2) == 0) ? pick_byte() : my_address);
			end else if (kind < 90) begin
				case ($urandom_range(0, 2))
					0: line_bytes.push_back(code_ack);
					1: line_bytes.push_back(code_nak);
					default: line_bytes.push_back(pick_byte());
				endcase
			end else begin
				repeat ($urandom_range(1, 6))
					line_bytes.push_back(8'($urandom_range(0, 255)));
			end
			pause_at = ($urandom_range(0, 49) == 0) ? $urandom_range(0, line_bytes.size() - 1) : -1;
			send_line(pause_at);
		end
	endtask

	// ack and nak while idle, plus bytes that idle must ignore, escape code included
	task automatic test_idle_codes();
		send_byte(code_ack);
		send_byte(code_nak);
		send_byte(8'hFF);
		send_byte(code_escape);
		send_byte(8'h00);
	endtask

	// repeated start-poll stays in poll, an own address after the escape code is compared unescaped
	task automatic test_poll_requests();
		send_byte(code_poll);
		send_byte(code_poll);
		send_byte(my_address);
		send_byte(code_poll);
		send_byte(code_escape);
		send_byte(my_address);
		send_byte(code_poll);
		send_byte(8'hFF);
	endtask

	// both substituted escape values in the payload of a good frame
	task automatic test_escaped_payload();
		open_frame(my_address, 8'h00, 8'hFF, 16'd2, 1'b0);
		add_field(code_start, 1'b0);
		add_field(code_poll, 1'b0);
		close_frame(1'b0);
		send_line(-1);
	endtask

	// longest declared length and an escaped address that is not ours
	task automatic test_frame_errors();
		open_frame(my_address, 8'hA5, 8'h5A, 16'hFFFF, 1'b0);
		send_line(-1);
		line_bytes = '{code_start, code_escape, ESC_SEQ_TWO};
		send_line(-1);
	endtask

	// sender holds off until every result is out, mid-header and mid-escape
	task automatic test_pause_mid_frame();
		open_frame(my_address, 8'h00, 8'h00, 16'd0, 1'b0);
		close_frame(1'b0);
		send_line(3);
		open_frame(my_address, 8'h3C, 8'hC3, 16'd1, 1'b0);
		add_field(code_escape, 1'b0);
		close_frame(1'b0);
		send_line(7);
	endtask

	task automatic test_default_traffic();
		run_traffic(250, 0, 0);
	endtask

	// codes at the ends of the byte range, ack and nak on the substitution values
	task automatic test_extreme_codes();
		write_registers(8'h00, 8'hFF, 8'h80, 8'h7F, 8'h8F, 8'hFE);
		run_traffic(250, 66, 0);
	endtask

	// overlapping codes exercise the idle priority, escape equal to a substitution byte
	task automatic test_colliding_codes();
		write_registers(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h02);
		run_traffic(250, 0, 66);
	endtask

	task automatic test_random_codes();
		write_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_traffic(250, 27, 27);
	endtask

	// result side: compare each popped beat with the oldest expectation, then
	// pick whether to pop at the next edge
	always @(posedge clk) begin : result_check
		rx_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				beats_checked++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected: ev %0d data %h cmd %h len %h",
							$time, event_res, data_byte, command_code, payload_length);
				end else begin
					want = pending_results.pop_front();
					tally[want.ev]++;
					if (event_res !== want.ev || data_byte !== want.data ||
							command_code !== want.cmd || payload_length !== want.len) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: expected ev %0d data %h cmd %h len %h, got ev %0d data %h cmd %h len %h",
								$time, want.ev, want.data, want.cmd, want.len,
								event_res, data_byte, command_code, payload_length);
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on beats of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending_results.size());
				$display("rs485_frame_receiver verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_codes();
		test_poll_requests();
		test_escaped_payload();
		test_frame_errors();
		test_pause_mid_frame();
		test_default_traffic();
		test_extreme_codes();
		test_colliding_codes();
		test_random_codes();
		wait_drained();
		// any stray beat after this point is caught by the result check
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d line bytes and %0d result beats over %0d register settings",
			bytes_sent, beats_checked, register_sets + 1);
		$display("events: %0d payload, %0d good, %0d bad, %0d poll, %0d ack, %0d nak, %0d none",
			tally[EV_DATA], tally[EV_GOOD], tally[EV_BAD], tally[EV_POLL],
			tally[EV_ACK], tally[EV_NAK], tally[EV_NONE]);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("rs485_frame_receiver verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				mismatch_count, pending_results.size());
			$display("rs485_frame_receiver verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/rsfr_pkg.sv
sv/rsfr_front.sv
sv/rsfr_fifo.sv
sv/rsfr_back.sv
sv/rs485_frame_receiver.sv
sv/rsfr_checker.sv
verif/rs485_frame_receiver_tb.sv
